### src/pcbs_pkg.sv
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared types, constants and the level/step table of the backlight stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcbs_pkg;

  localparam int DEF_STEPS     = 32;
  localparam int TABLE_SIZE    = 21;
  localparam int TABLE_ENTRIES = 21;
  localparam int TBL_N = (TABLE_ENTRIES > TABLE_SIZE) ? TABLE_SIZE : TABLE_ENTRIES;

  localparam logic [6:0] STEP_UNKNOWN = 7'h7F;
  localparam logic [6:0] MAX_PERCENT  = 7'd100;

  // level * 255 / 100 is taken as (level * 255 * RECIP_100) >> SCALE_SHIFT.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          SCALE_SHIFT = 19;

  localparam logic [7:0] MAP_LEVEL [TABLE_SIZE] = '{
    8'd255, 8'd244, 8'd233, 8'd222, 8'd211, 8'd200, 8'd189, 8'd178, 8'd166,
    8'd154, 8'd141, 8'd127, 8'd113, 8'd99, 8'd85, 8'd71, 8'd57, 8'd43,
    8'd30, 8'd20, 8'd0
  };

  localparam logic [5:0] MAP_STEP [TABLE_SIZE] = '{
    6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd17, 6'd19, 6'd21, 6'd23, 6'd24, 6'd26, 6'd28, 6'd29, 6'd30,
    6'd31, 6'd31, 6'd32
  };

  localparam int          ADDR_W      = 5;
  localparam logic [2:0] REG_DIM_THR  = 3'd0;
  localparam logic [2:0] REG_DIM_STEP = 3'd1;
  localparam logic [2:0] REG_HALF     = 3'd2;
  localparam logic [2:0] REG_HOLD     = 3'd3;
  localparam logic [2:0] REG_SETTLE   = 3'd4;

  typedef enum logic [1:0] {
    ACT_LOW    = 2'd0,
    ACT_HIGH   = 2'd1,
    ACT_PULSE  = 2'd2,
    ACT_SETTLE = 2'd3
  } action_t;

  typedef struct packed {
    logic [7:0]  dim_thr;
    logic [5:0]  dim_step;
    logic [9:0]  half_time;
    logic [15:0] hold_time;
    logic [15:0] settle_time;
  } cfg_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCALE,
    F_MAP,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RESET,
    B_WAKE,
    B_PULSE,
    B_SETTLE
  } back_state_t;

endpackage

`default_nettype wire

### src/pcbs_if.sv
// ----------------------------------------------------------------------------
// pcbs_if
// Valid/ready channels for brightness requests and line actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pcbs_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] brightness;
  logic       line_sampled_high;

  modport source (output valid, output brightness, output line_sampled_high, input ready);
  modport sink (input valid, input brightness, input line_sampled_high, output ready);
endinterface

interface pcbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] duration;
  logic        final_res;

  modport source (output valid, output action, output duration, output final_res, input ready);
  modport sink (input valid, input action, input duration, input final_res, output ready);
endinterface

`default_nettype wire

### src/pcbs_cfg.sv
// ----------------------------------------------------------------------------
// pcbs_cfg
// APB-style register file holding the stepper configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbs_cfg
  import pcbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_thr     <= 8'd30;
      cfg_r.dim_step    <= 6'd31;
      cfg_r.half_time   <= 10'd3;
      cfg_r.hold_time   <= 16'd3000;
      cfg_r.settle_time <= 16'd1000;
    end else if (wr_en) begin
      unique case (idx)
        REG_DIM_THR:  cfg_r.dim_thr     <= pwdata[7:0];
        REG_DIM_STEP: cfg_r.dim_step    <= pwdata[5:0];
        REG_HALF:     cfg_r.half_time   <= pwdata[9:0];
        REG_HOLD:     cfg_r.hold_time   <= pwdata[15:0];
        REG_SETTLE:   cfg_r.settle_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIM_THR:  prdata = 32'(cfg_r.dim_thr);
      REG_DIM_STEP: prdata = 32'(cfg_r.dim_step);
      REG_HALF:     prdata = 32'(cfg_r.half_time);
      REG_HOLD:     prdata = 32'(cfg_r.hold_time);
      REG_SETTLE:   prdata = 32'(cfg_r.settle_time);
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### src/pcbs_front.sv
// ----------------------------------------------------------------------------
// pcbs_front
// Scales a request, maps it to a target step and plans the line sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbs_front
  import pcbs_pkg::*;
#(
  parameter int STEPS = DEF_STEPS,
  parameter int PW    = $clog2(STEPS)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  pcbs_in_if.sink        in_bus,
  output logic           push,
  output logic [PW+1:0]  wdata,
  input  wire logic      full
);

  localparam int KS = ((63 + STEPS - 1) / STEPS) * STEPS;

  front_state_t state_r, state_nxt;
  logic [6:0]   cur_r;
  logic [14:0]  prod_r;
  logic         line_r;
  logic [7:0]   level_r;
  logic [6:0]   tgt_r;
  logic         hold_r;
  logic         wake_r;
  logic [7:0]   d_r;

  logic         accept;
  logic [6:0]   b_clamp;
  logic [27:0]  mul;
  logic [6:0]   tgt_map;
  logic [6:0]   tgt;
  logic         off;
  logic         unknown;
  logic         hold;
  logic         wake;
  logic [7:0]   cur_eff;
  logic         mod_done;

  assign accept   = in_bus.valid & in_bus.ready;
  assign b_clamp  = (in_bus.brightness > MAX_PERCENT) ? MAX_PERCENT : in_bus.brightness;
  assign mul      = 28'(prod_r) * 28'(RECIP_100);
  assign mod_done = (d_r < 8'(STEPS));

  always_comb begin
    tgt_map = '0;
    for (int i = TBL_N - 2; i >= 0; i--) begin
      if (level_r <= MAP_LEVEL[i] && level_r > MAP_LEVEL[i+1]) begin
        tgt_map = 7'(MAP_STEP[i]);
      end
    end
  end

  always_comb begin
    if (level_r == 8'd0) begin
      tgt = '0;
    end else if (level_r < cfg.dim_thr) begin
      tgt = 7'(cfg.dim_step);
    end else begin
      tgt = tgt_map;
    end
    off     = (tgt == 7'd0);
    unknown = (cur_r == STEP_UNKNOWN);
    hold    = off | (unknown & line_r);
    wake    = ~off & (hold | (cur_r == 7'd0));
    if (wake) begin
      cur_eff = 8'(STEPS);
    end else if (unknown) begin
      cur_eff = 8'hFF;
    end else begin
      cur_eff = 8'(cur_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_SCALE;
      F_SCALE: state_nxt = F_MAP;
      F_MAP:   state_nxt = F_MOD;
      F_MOD:   if (mod_done) state_nxt = F_PUSH;
      F_PUSH:  if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready = (state_r == F_IDLE);
    push         = (state_r == F_PUSH) & ~full;
    wdata        = {hold_r, wake_r, d_r[PW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cur_r   <= STEP_UNKNOWN;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        cur_r <= tgt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          prod_r <= {b_clamp, 8'd0} - 15'(b_clamp);
          line_r <= in_bus.line_sampled_high;
        end
      end
      F_SCALE: level_r <= mul[SCALE_SHIFT+7:SCALE_SHIFT];
      F_MAP: begin
        tgt_r  <= tgt;
        hold_r <= hold;
        wake_r <= wake;
        d_r    <= off ? 8'd0 : (8'(tgt) + 8'(KS) - cur_eff);
      end
      F_MOD: begin
        if (!mod_done) begin
          d_r <= d_r - 8'(STEPS);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/pcbs_fifo.sv
// ----------------------------------------------------------------------------
// pcbs_fifo
// Two-entry queue of planned sequences between planner and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbs_fifo #(
  parameter int W = 7
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/pcbs_back.sv
// ----------------------------------------------------------------------------
// pcbs_back
// Expands a planned sequence into line action words, one per ready cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbs_back
  import pcbs_pkg::*;
#(
  parameter int STEPS = DEF_STEPS,
  parameter int PW    = $clog2(STEPS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic [PW+1:0] rdata,
  input  wire logic          empty,
  output logic               pop,
  pcbs_out_if.source         out_bus
);

  back_state_t   state_r, state_nxt;
  logic          wake_r;
  logic [PW-1:0] cnt_r;
  logic          out_valid_r;
  action_t       act_r;
  logic [15:0]   dur_r;
  logic          fin_r;

  logic          emit;
  action_t       act_sel;
  logic [15:0]   dur_sel;

  function automatic back_state_t first_phase(logic h, logic w, logic [PW-1:0] c);
    back_state_t s;
    if (h) begin
      s = B_RESET;
    end else if (w) begin
      s = B_WAKE;
    end else if (c != '0) begin
      s = B_PULSE;
    end else begin
      s = B_SETTLE;
    end
    return s;
  endfunction

  assign emit = (state_r != B_IDLE) & (~out_valid_r | out_bus.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (!empty) state_nxt = first_phase(rdata[PW+1], rdata[PW], rdata[PW-1:0]);
      B_RESET:  if (emit) state_nxt = first_phase(1'b0, wake_r, cnt_r);
      B_WAKE:   if (emit) state_nxt = first_phase(1'b0, 1'b0, cnt_r);
      B_PULSE:  if (emit && cnt_r == PW'(1)) state_nxt = B_SETTLE;
      B_SETTLE: if (emit) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state_r == B_IDLE) & ~empty;
    act_sel = ACT_SETTLE;
    dur_sel = cfg.settle_time;
    unique case (state_r)
      B_RESET: begin
        act_sel = ACT_LOW;
        dur_sel = cfg.hold_time;
      end
      B_WAKE: begin
        act_sel = ACT_HIGH;
        dur_sel = 16'(cfg.half_time);
      end
      B_PULSE: begin
        act_sel = ACT_PULSE;
        dur_sel = 16'(cfg.half_time);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      wake_r <= rdata[PW];
      cnt_r  <= rdata[PW-1:0];
    end else if (emit && state_r == B_PULSE) begin
      cnt_r <= cnt_r - PW'(1);
    end
    if (emit) begin
      act_r <= act_sel;
      dur_r <= dur_sel;
      fin_r <= (state_r == B_SETTLE);
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.action    = act_r;
  assign out_bus.duration  = dur_r;
  assign out_bus.final_res = fin_r;

endmodule

`default_nettype wire

### src/pulse_count_backlight_stepper.sv
// ----------------------------------------------------------------------------
// pulse_count_backlight_stepper
// Turns brightness requests into one-wire pulse-count line actions.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Word
//   in_bus    in         valid/ready            brightness, line_sampled_high
//   out_bus   out        valid/ready            action, duration, final_res
//   cfg       in         APB psel/penable       five configuration registers
//
// The planner steps each request through SCALE, MAP, MOD (reducing d, below
// 190, by repeated subtraction of STEPS) and PUSH and takes no new one until
// PUSH is done; the sequencer sends one word per cycle while out_bus is ready.
// A two-entry queue lets the planner run ahead of the sequencer.
// Reset is synchronous, active low, and leaves the current step unknown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pulse_count_backlight_stepper
  import pcbs_pkg::*;
#(
  parameter int STEPS = DEF_STEPS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pcbs_in_if.sink                in_bus,
  pcbs_out_if.source             out_bus,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int PW = $clog2(STEPS);

  cfg_t          cfg;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  logic [PW+1:0] wdata;
  logic [PW+1:0] rdata;

  pcbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcbs_front #(.STEPS(STEPS), .PW(PW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_bus (in_bus),
    .push   (push),
    .wdata  (wdata),
    .full   (full)
  );

  pcbs_fifo #(.W(PW + 2)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  pcbs_back #(.STEPS(STEPS), .PW(PW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .rdata   (rdata),
    .empty   (empty),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-count backlight stepper.
// Brightness requests are sent on the request channel and every line action
// that comes back is compared field by field with a shadow model of the step
// planner, which tracks the chip step and the register settings of the bench.
// Both channels idle at random, and the registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pcbs_pkg::*;

  localparam int STEPS          = DEF_STEPS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_CYCLES     = 20;

  typedef struct packed {
    action_t     act;
    logic [15:0] dur;
    logic        last;
  } line_action_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pcbs_in_if  req_if ();
  pcbs_out_if act_if ();

  pulse_count_backlight_stepper #(
    .STEPS (STEPS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (req_if),
    .out_bus (act_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t         shadow_cfg;
  logic [6:0]   chip_step;
  line_action_t pending_actions[$];
  int           n_errors;
  int           idle_cycles;
  bit           steady;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [6:0] lookup_step(int level);
    if (level == 0) begin
      return 7'd0;
    end
    if (level < int'(shadow_cfg.dim_thr)) begin
      return {1'b0, shadow_cfg.dim_step};
    end
    for (int i = 0; i + 1 < TBL_N; i++) begin
      if (level <= int'(MAP_LEVEL[i]) && level > int'(MAP_LEVEL[i + 1])) begin
        return {1'b0, MAP_STEP[i]};
      end
    end
    return 7'd0;
  endfunction

  function automatic void add_action(action_t act, logic [15:0] dur, logic last);
    line_action_t a;
    a.act  = act;
    a.dur  = dur;
    a.last = last;
    pending_actions.push_back(a);
  endfunction

  function automatic void plan_actions(logic [6:0] pct, logic line_hi);
    int level;
    int cur;
    int pulses;
    logic [6:0] tgt;
    level = ((pct > MAX_PERCENT) ? 100 : int'(pct)) * 255 / 100;
    tgt = lookup_step(level);
    if (tgt == 7'd0) begin
      add_action(ACT_LOW, shadow_cfg.hold_time, 1'b0);
      chip_step = 7'd0;
    end else begin
      if (chip_step == STEP_UNKNOWN && line_hi) begin
        add_action(ACT_LOW, shadow_cfg.hold_time, 1'b0);
        chip_step = 7'd0;
      end
      if (chip_step == 7'd0) begin
        add_action(ACT_HIGH, {6'd0, shadow_cfg.half_time}, 1'b0);
        chip_step = 7'(STEPS);
      end
      cur = (chip_step == STEP_UNKNOWN) ? -1 : int'(chip_step);
      pulses = (((int'(tgt) - cur) % STEPS) + STEPS) % STEPS;
      repeat (pulses) add_action(ACT_PULSE, {6'd0, shadow_cfg.half_time}, 1'b0);
      chip_step = tgt;
    end
    add_action(ACT_SETTLE, shadow_cfg.settle_time, 1'b1);
  endfunction

  always @(negedge clk) begin
    act_if.ready = steady || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin : action_check
    line_action_t want;
    if (rst_n && act_if.valid && act_if.ready) begin
      if (pending_actions.size() == 0) begin
        $error("unexpected word: action %0d, duration %0d, final_res %0d",
               act_if.action, act_if.duration, act_if.final_res);
        n_errors++;
      end else begin
        want = pending_actions.pop_front();
        if (act_if.action !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, act_if.action);
          n_errors++;
        end
        if (act_if.duration !== want.dur) begin
          $error("duration: expected %0d, got %0d", want.dur, act_if.duration);
          n_errors++;
        end
        if (act_if.final_res !== want.last) begin
          $error("final_res: expected %0d, got %0d", want.last, act_if.final_res);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (act_if.valid && act_if.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(logic [6:0] pct, logic line_hi);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 21) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    req_if.brightness        = pct;
    req_if.line_sampled_high = line_hi;
    req_if.valid             = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    plan_actions(pct, line_hi);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DIM_THR:  shadow_cfg.dim_thr     = val[7:0];
      REG_DIM_STEP: shadow_cfg.dim_step    = val[5:0];
      REG_HALF:     shadow_cfg.half_time   = val[9:0];
      REG_HOLD:     shadow_cfg.hold_time   = val[15:0];
      REG_SETTLE:   shadow_cfg.settle_time = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_all(logic [31:0] thr, logic [31:0] stp, logic [31:0] half,
                           logic [31:0] hold, logic [31:0] settle);
    write_reg(REG_DIM_THR, thr);
    write_reg(REG_DIM_STEP, stp);
    write_reg(REG_HALF, half);
    write_reg(REG_HOLD, hold);
    write_reg(REG_SETTLE, settle);
  endtask

  function automatic logic [6:0] random_percent();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return 7'd0;
    end
    if (pick < 20) begin
      return 7'($urandom_range(127, 101));
    end
    if (pick < 30) begin
      return 7'($urandom_range(12, 1));
    end
    return 7'($urandom_range(100, 1));
  endfunction

  task automatic test_unknown_start();
    send_request(7'd50, 1'($urandom_range(1)));
    wait_drained();
  endtask

  task automatic test_directed_levels();
    logic [6:0] levels[$] = '{7'd50, 7'd100, 7'd127, 7'd101, 7'd0, 7'd1, 7'd0, 7'd12,
                              7'd11, 7'd8, 7'd9, 7'd40, 7'h55, 7'h2A, 7'd65, 7'd99,
                              7'd96, 7'd0, 7'd0};
    foreach (levels[i]) send_request(levels[i], 1'(i));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_all(32'd0, 32'd63, 32'd1023, 32'd65535, 32'd65535);
    send_request(7'd1, 1'b1);
    send_request(7'd50, 1'b0);
    send_request(7'd100, 1'b1);
    send_request(7'd0, 1'b0);
    send_request(7'd5, 1'b1);
    wait_drained();
    write_all(32'd255, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(7'd50, 1'b0);
    send_request(7'd100, 1'b1);
    send_request(7'd3, 1'b0);
    wait_drained();
    // Bits above each register's width must be dropped by the block.
    write_all(32'hFFFF_FF40, 32'hFFFF_FFC1, 32'hFFFF_FC00, 32'hABCD_0000, 32'h5555_FFFF);
    send_request(7'd20, 1'b1);
    send_request(7'd30, 1'b0);
    send_request(7'd0, 1'b1);
    wait_drained();
    write_all(32'd30, 32'd31, 32'd3, 32'd3000, 32'd1000);
  endtask

  task automatic test_random_traffic(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        wait_drained();
        if ($urandom_range(3) == 0) begin
          write_all(32'($urandom_range(60, 20)), 32'($urandom_range(63, 1)),
                    32'($urandom_range(1023, 1)), $urandom(), $urandom());
        end else begin
          write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end
      end
      send_request(random_percent(), 1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  task automatic test_steady_stream(int n_items);
    steady = 1'b1;
    repeat (n_items) send_request(random_percent(), 1'($urandom_range(1)));
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    rst_n                    = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    req_if.valid             = 1'b0;
    req_if.brightness        = '0;
    req_if.line_sampled_high = 1'b0;
    act_if.ready             = 1'b0;
    steady                   = 1'b0;
    n_errors                 = 0;
    idle_cycles              = 0;
    chip_step                = STEP_UNKNOWN;
    shadow_cfg.dim_thr       = 8'd30;
    shadow_cfg.dim_step      = 6'd31;
    shadow_cfg.half_time     = 10'd3;
    shadow_cfg.hold_time     = 16'd3000;
    shadow_cfg.settle_time   = 16'd1000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unknown_start();
    test_directed_levels();
    test_register_extremes();
    test_random_traffic(290);
    test_steady_stream(60);

    repeat (END_CYCLES) @(posedge clk);
    if (n_errors == 0 && pending_actions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
src/pcbs_pkg.sv
src/pcbs_if.sv
src/pcbs_cfg.sv
src/pcbs_front.sv
src/pcbs_fifo.sv
src/pcbs_back.sv
src/pulse_count_backlight_stepper.sv
sim/tb_top.sv
